### design/sfi_pkg.sv
// ----------------------------------------------------------------------------
// sfi_pkg: shared types and constants for the steering force integrator
// Register indexes, sequencer states, unit opcodes and fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sfi_pkg;

  // speed threshold 0.001 in Q16.16
  localparam logic [63:0] EpsQ16 = 64'd66;

  localparam logic [30:0] MaxSpeedRst = 31'd327680;
  localparam logic [30:0] BrakeRst    = 31'd0;
  localparam logic [30:0] MaxAdjRst   = 31'd65536;
  localparam logic signed [15:0] HeadZRst = 16'sd16384;

  // quotient widths of the divides and step count of the root
  localparam logic [5:0] DivBitsRatio = 6'd32;
  localparam logic [5:0] DivBitsUnit  = 6'd31;
  localparam logic [5:0] DivBitsHead  = 6'd18;
  localparam logic [5:0] SqrtSteps    = 6'd32;

  typedef enum logic [1:0] {
    CFG_MAX_SPEED = 2'd0,
    CFG_BRAKING   = 2'd1,
    CFG_MAX_ADJ   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    DS_DIV  = 1'b0,
    DS_SQRT = 1'b1
  } ds_op_t;

  typedef struct packed {
    logic       start;
    ds_op_t     op;
    logic [5:0] nbits;
  } ds_req_t;

  typedef enum logic [1:0] {
    MP_IDLE = 2'd0,
    MP_LO   = 2'd1,
    MP_HI   = 2'd2,
    MP_SUM  = 2'd3
  } mul_ph_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BRAKE, ST_FSQ, ST_FSQRT, ST_RDIV, ST_POW, ST_DOT, ST_CONE,
    ST_PP, ST_NORM, ST_PSQ, ST_PSQRT, ST_UDIV, ST_CSQ, ST_PDSQRT,
    ST_NF1, ST_NF2, ST_NF3, ST_VH, ST_VF, ST_VSH, ST_VSQ, ST_VSQRT,
    ST_QDIV, ST_QHI, ST_QLO, ST_HDIV, ST_DONE
  } sfi_state_t;

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    abs64 = x[63] ? (64'd0 - x) : x;
  endfunction

  // signed shift right that rounds toward zero
  function automatic logic signed [63:0] tz_shr(input logic signed [63:0] x,
                                                input int unsigned k);
    logic [63:0] mag;
    logic [63:0] sh;
    mag = abs64(x);
    sh  = mag >> k;
    tz_shr = x[63] ? $signed(64'd0 - sh) : $signed(sh);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) sat32 = 32'sh7FFFFFFF;
    else if (x < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = x[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
    if (x > 64'sd32767) sat16 = 16'sh7FFF;
    else if (x < -64'sd32768) sat16 = 16'sh8000;
    else sat16 = x[15:0];
  endfunction

endpackage

`default_nettype wire

### design/sfi_mul.sv
// ----------------------------------------------------------------------------
// sfi_mul: two-pass multiplier
// 64-bit signed times 33-bit signed, low 64 bits, over one 33x33 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module sfi_mul import sfi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [32:0] b,
  output logic               done,
  output logic signed [63:0] prod
);

  mul_ph_t            ph_r;
  logic signed [63:0] a_r;
  logic signed [32:0] b_r;
  logic        [63:0] p_r;
  logic        [63:0] acc_r;
  logic               done_r;
  logic signed [32:0] mop_a;
  logic signed [65:0] mres;

  // low word as unsigned, then high word signed
  assign mop_a = (ph_r == MP_LO) ? $signed({1'b0, a_r[31:0]})
                                 : $signed({a_r[63], a_r[63:32]});
  assign mres  = mop_a * b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= MP_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (ph_r)
        MP_IDLE: begin
          if (start) begin
            a_r  <= a;
            b_r  <= b;
            ph_r <= MP_LO;
          end
        end
        MP_LO: begin
          p_r  <= mres[63:0];
          ph_r <= MP_HI;
        end
        MP_HI: begin
          acc_r <= p_r;
          p_r   <= mres[63:0];
          ph_r  <= MP_SUM;
        end
        default: begin
          acc_r  <= acc_r + {p_r[31:0], 32'd0};
          done_r <= 1'b1;
          ph_r   <= MP_IDLE;
        end
      endcase
    end
  end

  assign done = done_r;
  assign prod = $signed(acc_r);

endmodule

`default_nettype wire

### design/sfi_divsqrt.sv
// ----------------------------------------------------------------------------
// sfi_divsqrt: iterative divide / square root
// One compare-subtract per cycle; restoring divide or floor integer root.
// ----------------------------------------------------------------------------
`default_nettype none

module sfi_divsqrt import sfi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ds_req_t     req,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] res
);

  ds_op_t      op_r;
  logic [63:0] a_r;
  logic [63:0] r_r;
  logic [63:0] w_r;
  logic [63:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] x;
  logic [63:0] y;
  logic [63:0] diff;
  logic        ge;

  always_comb begin
    x    = (op_r == DS_DIV) ? {a_r[62:0], w_r[63]} : a_r;
    y    = (op_r == DS_DIV) ? den_r : (r_r + w_r);
    ge   = (x >= y);
    diff = x - y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          busy_r <= 1'b1;
          op_r   <= req.op;
          den_r  <= den;
          r_r    <= '0;
          if (req.op == DS_DIV) begin
            a_r   <= num >> req.nbits;
            w_r   <= num << (7'd64 - {1'b0, req.nbits});
            cnt_r <= req.nbits;
          end else begin
            a_r   <= num;
            w_r   <= 64'h4000_0000_0000_0000;
            cnt_r <= SqrtSteps;
          end
        end
      end else begin
        if (op_r == DS_DIV) begin
          a_r <= ge ? diff : x;
          r_r <= {r_r[62:0], ge};
          w_r <= w_r << 1;
        end else begin
          if (ge) begin
            a_r <= diff;
            r_r <= (r_r >> 1) + w_r;
          end else begin
            r_r <= r_r >> 1;
          end
          w_r <= w_r >> 2;
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = r_r;

endmodule

`default_nettype wire

### design/steering_force_integrator_core.sv
// ----------------------------------------------------------------------------
// steering_force_integrator_core: fixed-point vehicle velocity update
// Applies braking, cone limit on the steering force, integration, speed
// saturation and heading realignment, one force transfer at a time.
// ----------------------------------------------------------------------------
// Each accepted force transfer yields exactly one velocity transfer. The
// block works on one item at a time and holds in_stall high from the accept
// until the result has been loaded into the output register; a result that
// waits on out_stall does not block the next accept. Item time is set by
// one shared divide/root unit (one bit per cycle: 32 steps per root, 32,
// 31 or 18 steps per divide) and by one two-pass multiplier, both driven
// by the sequencer below, and grows when the cone limit applies. Heading
// and speed state persist between items; the config registers (max speed,
// braking, max adjusted speed) are always writable (cfg_ready is tied high)
// and must only change while idle.
`default_nettype none

module steering_force_integrator_core import sfi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // force input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_force_x,
  input  logic signed [31:0] in_force_y,
  input  logic signed [31:0] in_force_z,
  input  logic        [15:0] in_step_time,
  // velocity result
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z,
  // config writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [1:0]  cfg_index,
  input  logic        [30:0] cfg_data
);

  // config and persistent state
  logic        [30:0] max_r, brake_r, mas_r;
  logic signed [15:0] h_r [3];
  logic        [30:0] spd_r;

  // per-item working registers
  sfi_state_t         state_r, state_nxt;
  logic               pend_r;
  logic        [2:0]  idx_r;
  logic signed [63:0] f_r [3];
  logic        [15:0] dt_r;
  logic        [63:0] sp_r;
  logic        [31:0] flen_r;
  logic        [31:0] r_r, r4_r;
  logic signed [29:0] cone_r;
  logic signed [63:0] dot_r, acc_r, t_r, d_r;
  logic signed [63:0] pp_r [3];
  logic        [63:0] m_r;
  logic        [31:0] len_r;
  logic signed [31:0] u_r [3];
  logic        [28:0] pd_r;
  logic signed [63:0] v_r [3];
  logic        [63:0] av_r [3];
  logic        [5:0]  s_r;
  logic        [31:0] q_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;

  // unit interfaces
  logic               mul_start, mul_done;
  logic signed [63:0] mul_a, mul_prod;
  logic signed [32:0] mul_b;
  ds_req_t            ds_req;
  logic        [63:0] ds_num, ds_den, ds_res;
  logic               ds_done;
  logic               uses_mul, uses_ds, step_done;

  // helpers
  logic        [1:0]  i;
  logic               last;
  logic               in_xfer, out_free;
  logic        [63:0] fa, va;
  logic               cone_go, outside;
  logic signed [63:0] ppnew, vnew;
  logic        [63:0] ppabs, mpp, vabs, mv, sp_new, amag;
  logic signed [30:0] cone_w;
  logic signed [63:0] hq;

  sfi_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  sfi_divsqrt u_ds (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ds_req),
    .num   (ds_num),
    .den   (ds_den),
    .done  (ds_done),
    .res   (ds_res)
  );

  assign i        = idx_r[1:0];
  assign last     = (idx_r == 3'd2);
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // per-step values derived from the unit results
  always_comb begin
    fa      = abs64(f_r[i]);
    va      = abs64(v_r[i]);
    cone_go = (ds_res[31:0] >= EpsQ16[31:0]) && (sp_r < {33'd0, mas_r});
    outside = (dot_r <<< 14) < mul_prod;
    ppnew   = (f_r[i] <<< 14) - tz_shr(mul_prod, 14);
    ppabs   = abs64(ppnew);
    mpp     = (idx_r == 3'd0 || ppabs > m_r) ? ppabs : m_r;
    vnew    = t_r + tz_shr(mul_prod, 16);
    vabs    = abs64(vnew);
    mv      = (idx_r == 3'd0 || vabs > m_r) ? vabs : m_r;
    sp_new  = ds_res << s_r;
    amag    = ($unsigned(t_r) + ($unsigned(mul_prod) >> 16)) >> 16;
    cone_w  = 31'sd268435456 - $signed({2'b00, mul_prod[63:35]});
    hq      = v_r[i][63] ? $signed(64'd0 - ds_res) : $signed(ds_res);
  end

  // sequencer: operand steering and next state
  always_comb begin
    state_nxt = state_r;
    uses_mul  = 1'b0;
    uses_ds   = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    ds_req.op    = DS_DIV;
    ds_req.nbits = DivBitsRatio;
    ds_num    = '0;
    ds_den    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_BRAKE;
      end
      ST_BRAKE: begin
        uses_mul = 1'b1;
        mul_a = {33'd0, brake_r};
        mul_b = {17'd0, dt_r};
        if (step_done) state_nxt = ST_FSQ;
      end
      ST_FSQ: begin
        uses_mul = 1'b1;
        mul_a = fa;
        mul_b = fa[32:0];
        if (step_done && last) state_nxt = ST_FSQRT;
      end
      ST_FSQRT: begin
        uses_ds = 1'b1;
        ds_req.op = DS_SQRT;
        ds_num = acc_r;
        if (step_done) state_nxt = cone_go ? ST_RDIV : ST_VH;
      end
      ST_RDIV: begin
        uses_ds = 1'b1;
        ds_num = {sp_r[31:0], 32'd0};
        ds_den = {33'd0, mas_r};
        if (step_done) state_nxt = ST_POW;
      end
      ST_POW: begin
        uses_mul = 1'b1;
        mul_a = {32'd0, r_r};
        mul_b = (idx_r == 3'd4) ? {1'b0, r4_r} : {1'b0, r_r};
        if (step_done && idx_r == 3'd4) state_nxt = ST_DOT;
      end
      ST_DOT: begin
        uses_mul = 1'b1;
        mul_a = f_r[i];
        mul_b = {{17{h_r[i][15]}}, h_r[i]};
        if (step_done && last) state_nxt = ST_CONE;
      end
      ST_CONE: begin
        uses_mul = 1'b1;
        mul_a = {{34{cone_r[29]}}, cone_r};
        mul_b = {1'b0, flen_r};
        if (step_done) state_nxt = outside ? ST_PP : ST_VH;
      end
      ST_PP: begin
        uses_mul = 1'b1;
        mul_a = dot_r;
        mul_b = {{17{h_r[i][15]}}, h_r[i]};
        if (step_done && last) state_nxt = (mpp == 64'd0) ? ST_CSQ : ST_NORM;
      end
      ST_NORM: begin
        if (m_r < 64'h2000_0000 || m_r >= 64'h4000_0000) state_nxt = ST_NORM;
        else state_nxt = ST_PSQ;
      end
      ST_PSQ: begin
        uses_mul = 1'b1;
        mul_a = pp_r[i];
        mul_b = pp_r[i][32:0];
        if (step_done && last) state_nxt = ST_PSQRT;
      end
      ST_PSQRT: begin
        uses_ds = 1'b1;
        ds_req.op = DS_SQRT;
        ds_num = acc_r;
        if (step_done) state_nxt = ST_UDIV;
      end
      ST_UDIV: begin
        uses_ds = 1'b1;
        ds_req.nbits = DivBitsUnit;
        ds_num = abs64(pp_r[i]) << 30;
        ds_den = {32'd0, len_r};
        if (step_done && last) state_nxt = ST_CSQ;
      end
      ST_CSQ: begin
        uses_mul = 1'b1;
        mul_a = {{34{cone_r[29]}}, cone_r};
        mul_b = {{3{cone_r[29]}}, cone_r};
        if (step_done) state_nxt = ST_PDSQRT;
      end
      ST_PDSQRT: begin
        uses_ds = 1'b1;
        ds_req.op = DS_SQRT;
        ds_num = (64'd1 << 56) - acc_r;
        if (step_done) state_nxt = ST_NF1;
      end
      ST_NF1: begin
        uses_mul = 1'b1;
        mul_a = {{34{cone_r[29]}}, cone_r};
        mul_b = {{17{h_r[i][15]}}, h_r[i]};
        if (step_done) state_nxt = ST_NF2;
      end
      ST_NF2: begin
        uses_mul = 1'b1;
        mul_a = {{32{u_r[i][31]}}, u_r[i]};
        mul_b = {4'd0, pd_r};
        if (step_done) state_nxt = ST_NF3;
      end
      ST_NF3: begin
        uses_mul = 1'b1;
        mul_a = d_r;
        mul_b = {1'b0, flen_r};
        if (step_done) state_nxt = last ? ST_VH : ST_NF1;
      end
      ST_VH: begin
        uses_mul = 1'b1;
        mul_a = sp_r;
        mul_b = {{17{h_r[i][15]}}, h_r[i]};
        if (step_done) state_nxt = ST_VF;
      end
      ST_VF: begin
        uses_mul = 1'b1;
        mul_a = f_r[i];
        mul_b = {17'd0, dt_r};
        if (step_done) state_nxt = last ? ST_VSH : ST_VH;
      end
      ST_VSH: begin
        if (m_r <= 64'h8000_0000) state_nxt = ST_VSQ;
      end
      ST_VSQ: begin
        uses_mul = 1'b1;
        mul_a = av_r[i];
        mul_b = av_r[i][32:0];
        if (step_done && last) state_nxt = ST_VSQRT;
      end
      ST_VSQRT: begin
        uses_ds = 1'b1;
        ds_req.op = DS_SQRT;
        ds_num = acc_r;
        if (step_done) begin
          if (sp_new > {33'd0, max_r}) state_nxt = ST_QDIV;
          else if (sp_new > EpsQ16) state_nxt = ST_HDIV;
          else state_nxt = ST_DONE;
        end
      end
      ST_QDIV: begin
        uses_ds = 1'b1;
        ds_num = {1'b0, max_r, 32'd0};
        ds_den = sp_r;
        if (step_done) state_nxt = ST_QHI;
      end
      ST_QHI: begin
        uses_mul = 1'b1;
        mul_a = va;
        mul_b = {17'd0, q_r[31:16]};
        if (step_done) state_nxt = ST_QLO;
      end
      ST_QLO: begin
        uses_mul = 1'b1;
        mul_a = va;
        mul_b = {17'd0, q_r[15:0]};
        if (step_done) begin
          if (!last) state_nxt = ST_QHI;
          else if ({33'd0, max_r} > EpsQ16) state_nxt = ST_HDIV;
          else state_nxt = ST_DONE;
        end
      end
      ST_HDIV: begin
        uses_ds = 1'b1;
        ds_req.nbits = DivBitsHead;
        ds_num = va << 14;
        ds_den = sp_r;
        if (step_done && last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    mul_start    = uses_mul && !pend_r;
    ds_req.start = uses_ds && !pend_r;
    step_done    = pend_r && ((uses_mul && mul_done) || (uses_ds && ds_done));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // config, persistent state, handshake control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= MaxSpeedRst;
      brake_r     <= BrakeRst;
      mas_r       <= MaxAdjRst;
      h_r[0]      <= '0;
      h_r[1]      <= '0;
      h_r[2]      <= HeadZRst;
      spd_r       <= '0;
      pend_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MAX_SPEED: max_r   <= cfg_data;
          CFG_BRAKING:   brake_r <= cfg_data;
          CFG_MAX_ADJ:   mas_r   <= cfg_data;
          default: ;
        endcase
      end

      if (step_done) pend_r <= 1'b0;
      else if (mul_start || ds_req.start) pend_r <= 1'b1;

      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      // index bookkeeping for the per-component loops
      if (step_done) begin
        case (state_r)
          ST_FSQ, ST_DOT, ST_PP, ST_PSQ, ST_UDIV, ST_NF3, ST_VF, ST_VSQ,
          ST_QLO, ST_HDIV:
            idx_r <= last ? 3'd0 : idx_r + 3'd1;
          ST_POW:
            idx_r <= (idx_r == 3'd4) ? 3'd0 : idx_r + 3'd1;
          default: ;
        endcase
      end

      if (state_r == ST_HDIV && step_done) h_r[i] <= sat16(hq);

      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
        spd_r       <= sp_r[30:0];
      end
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      f_r[0] <= {{32{in_force_x[31]}}, in_force_x};
      f_r[1] <= {{32{in_force_y[31]}}, in_force_y};
      f_r[2] <= {{32{in_force_z[31]}}, in_force_z};
      dt_r   <= in_step_time;
      sp_r   <= {33'd0, spd_r};
      acc_r  <= '0;
    end
    if (state_r == ST_NORM) begin
      // bring the largest component into [2^29, 2^30)
      if (m_r >= 64'h4000_0000) begin
        for (int k = 0; k < 3; k++) pp_r[k] <= tz_shr(pp_r[k], 1);
        m_r <= m_r >> 1;
      end else if (m_r < 64'h2000_0000) begin
        for (int k = 0; k < 3; k++) pp_r[k] <= pp_r[k] <<< 1;
        m_r <= m_r << 1;
      end else begin
        acc_r <= '0;
      end
    end
    if (state_r == ST_VSH) begin
      // drop low bits until the largest component is at most 2^31
      if (m_r > 64'h8000_0000) begin
        for (int k = 0; k < 3; k++) av_r[k] <= av_r[k] >> 1;
        m_r <= m_r >> 1;
        s_r <= s_r + 6'd1;
      end else begin
        acc_r <= '0;
      end
    end
    if (step_done) begin
      case (state_r)
        ST_BRAKE: begin
          sp_r  <= (sp_r > ($unsigned(mul_prod) >> 16))
                   ? sp_r - ($unsigned(mul_prod) >> 16) : 64'd0;
          acc_r <= '0;
        end
        ST_FSQ, ST_DOT, ST_PSQ, ST_VSQ: begin
          acc_r <= acc_r + mul_prod;
          if (state_r == ST_DOT && last) dot_r <= acc_r + mul_prod;
        end
        ST_FSQRT: flen_r <= ds_res[31:0];
        ST_RDIV:  r_r    <= ds_res[31:0];
        ST_POW: begin
          r_r <= mul_prod[63:32];
          if (idx_r == 3'd1) r4_r <= mul_prod[63:32];
          if (idx_r == 3'd4) begin
            cone_r <= cone_w[29:0];
            acc_r  <= '0;
          end
        end
        ST_PP: begin
          pp_r[i] <= ppnew;
          m_r     <= mpp;
          if (last && mpp == 64'd0) begin
            u_r[0] <= 32'sh4000_0000;
            u_r[1] <= '0;
            u_r[2] <= '0;
          end
        end
        ST_PSQRT: len_r <= ds_res[31:0];
        ST_UDIV: u_r[i] <= pp_r[i][63] ? $signed(32'd0 - ds_res[31:0])
                                       : $signed(ds_res[31:0]);
        ST_CSQ:    acc_r <= mul_prod;
        ST_PDSQRT: pd_r  <= ds_res[28:0];
        ST_NF1:    t_r   <= tz_shr(mul_prod, 14);
        ST_NF2:    d_r   <= t_r + tz_shr(mul_prod, 30);
        ST_NF3:    f_r[i] <= tz_shr(mul_prod, 28);
        ST_VH:     t_r   <= tz_shr(mul_prod, 14);
        ST_VF: begin
          v_r[i]  <= vnew;
          av_r[i] <= vabs;
          m_r     <= mv;
          s_r     <= '0;
        end
        ST_VSQRT: sp_r <= sp_new;
        ST_QDIV:  q_r  <= ds_res[31:0];
        ST_QHI:   t_r  <= mul_prod;
        ST_QLO: begin
          v_r[i] <= v_r[i][63] ? $signed(64'd0 - amag) : $signed(amag);
          if (last) sp_r <= {33'd0, max_r};
        end
        default: ;
      endcase
    end
    if (state_r == ST_DONE && out_free) begin
      out_x_r <= sat32(v_r[0]);
      out_y_r <= sat32(v_r[1]);
      out_z_r <= sat32(v_r[2]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_vel_x = out_x_r;
  assign out_vel_y = out_y_r;
  assign out_vel_z = out_z_r;

endmodule

`default_nettype wire
